/* src/assert_macros.svh */
// Assertion macros for the checker file of this block.
// Each macro samples on posedge clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle
`define KQSB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle
`define KQSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/kqsb_pkg.sv */
// Shared field widths and codes for the shared-buffer queue block.
// No dependencies; imported by the interfaces, the top level and the checker.
`default_nettype none

package kqsb_pkg;

  localparam int ACTION_W = 1;
  localparam int QID_W    = 2;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // Requested operation
  localparam logic [ACTION_W-1:0] ACT_ENQUEUE = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 1'b1;

  // Result status
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

`default_nettype wire

/* src/kqsb_if.sv */
// Valid/ready channel interfaces for requests and results.
// Depends on kqsb_pkg for the field widths.
`default_nettype none

interface kqsb_in_if import kqsb_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic [QID_W-1:0]           queue_id;
  logic signed [DATA_W-1:0]   data_in;

  modport source (output valid, output action, output queue_id, output data_in,
                  input ready);
  modport sink   (input valid, input action, input queue_id, input data_in,
                  output ready);
endinterface

interface kqsb_out_if import kqsb_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [DATA_W-1:0]   data_out;
  logic [STATUS_W-1:0]        status;

  modport source (output valid, output data_out, output status, input ready);
  modport sink   (input valid, input data_out, input status, output ready);
endinterface

`default_nettype wire

/* src/kqsb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kqsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; read data holds when not read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* src/k_queues_shared_buffer.sv */
// Top level: several FIFO queues threaded through one shared slot pool.
// Depends on kqsb_pkg, kqsb_if (channels) and kqsb_ram (link, data, queue table).
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    action, queue_id, data_in
//   out_ch   out  valid/ready    data_out, status
//
// One request at a time. Enqueue, overflow and underflow reach the result
// register from S_LOOK; a good dequeue goes on through S_DEQ, since the queue table
// read must return the head slot before the link and data memories are read.
// Every memory read returns registered data.
// Reset (rst_n low, synchronous) empties all queues and restarts the free list;
// a fill counter stands in for the initial slot chain, so no clearing pass runs.
// A new request is taken while a result waits; a stalled result holds the
// next request in its decide step (S_LOOK).
`default_nettype none

module k_queues_shared_buffer import kqsb_pkg::*; #(
  parameter int SLOTS      = 16,
  parameter int QUEUES     = 4,
  parameter int DATA_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  kqsb_in_if.sink     in_ch,
  kqsb_out_if.source  out_ch
);

  localparam int SW = $clog2(SLOTS);
  localparam int PW = $clog2(SLOTS + 1);
  localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam logic [PW-1:0] NIL = PW'(SLOTS);

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_DEQ} state_t;

  state_t                state_r, state_nxt;
  logic [PW-1:0]         free_head_r, free_head_nxt;
  logic [PW-1:0]         fill_r, fill_nxt;
  logic [QUEUES-1:0]     qvalid_r, qvalid_nxt;
  logic [ACTION_W-1:0]   act_r, act_nxt;
  logic [QW-1:0]         q_r, q_nxt;
  logic                  qok_r, qok_nxt;
  logic [DATA_WIDTH-1:0] din_r, din_nxt;
  logic [PW-1:0]         head_r, head_nxt;
  logic [PW-1:0]         tail_r, tail_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]     out_data_r, out_data_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  // Memory ports
  logic                  link_we, link_re;
  logic [SW-1:0]         link_waddr, link_raddr;
  logic [PW-1:0]         link_wdata, link_rdata;
  logic                  data_we, data_re;
  logic [SW-1:0]         data_waddr, data_raddr;
  logic [DATA_WIDTH-1:0] data_wdata, data_rdata;
  logic                  qtab_we, qtab_re;
  logic [QW-1:0]         qtab_waddr, qtab_raddr;
  logic [2*PW-1:0]       qtab_wdata, qtab_rdata;

  logic                  in_fire, out_free, in_qok;
  logic [PW-1:0]         cur_head, cur_tail;
  logic [63:0]           din_64, dout_64;

  kqsb_ram #(.WIDTH(PW), .DEPTH(SLOTS), .AW(SW)) u_link_ram (
    .clk(clk), .wr_en(link_we), .wr_addr(link_waddr), .wr_data(link_wdata),
    .rd_en(link_re), .rd_addr(link_raddr), .rd_data(link_rdata)
  );

  kqsb_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS), .AW(SW)) u_data_ram (
    .clk(clk), .wr_en(data_we), .wr_addr(data_waddr), .wr_data(data_wdata),
    .rd_en(data_re), .rd_addr(data_raddr), .rd_data(data_rdata)
  );

  kqsb_ram #(.WIDTH(2 * PW), .DEPTH(QUEUES), .AW(QW)) u_qtab_ram (
    .clk(clk), .wr_en(qtab_we), .wr_addr(qtab_waddr), .wr_data(qtab_wdata),
    .rd_en(qtab_re), .rd_addr(qtab_raddr), .rd_data(qtab_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_qok      = (32'(in_ch.queue_id) < QUEUES);

  // Store data zero-extended, then cut to the configured width
  assign din_64  = {32'b0, in_ch.data_in};
  assign dout_64 = 64'(data_rdata);

  // Queue table entry: an entry never written reads as an empty queue
  assign cur_head = (qok_r && qvalid_r[q_r]) ? qtab_rdata[2*PW-1:PW] : NIL;
  assign cur_tail = qtab_rdata[PW-1:0];

  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    fill_nxt       = fill_r;
    qvalid_nxt     = qvalid_r;
    act_nxt        = act_r;
    q_nxt          = q_r;
    qok_nxt        = qok_r;
    din_nxt        = din_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;

    link_we    = 1'b0;
    link_waddr = '0;
    link_wdata = '0;
    link_re    = 1'b0;
    link_raddr = free_head_r[SW-1:0];
    data_we    = 1'b0;
    data_waddr = free_head_r[SW-1:0];
    data_wdata = din_r;
    data_re    = 1'b0;
    data_raddr = cur_head[SW-1:0];
    qtab_we    = 1'b0;
    qtab_waddr = q_r;
    qtab_wdata = '0;
    qtab_re    = 1'b0;
    qtab_raddr = QW'(in_ch.queue_id);

    case (state_r)
      // Take a request; fetch the queue entry and the free-list successor
      S_IDLE: begin
        if (in_fire) begin
          act_nxt   = in_ch.action;
          q_nxt     = QW'(in_ch.queue_id);
          qok_nxt   = in_qok;
          din_nxt   = din_64[DATA_WIDTH-1:0];
          qtab_re   = in_qok;
          link_re   = (free_head_r != NIL);
          state_nxt = S_LOOK;
        end
      end

      // Decide; enqueue and underflow complete here, a good dequeue fetches the head slot
      S_LOOK: begin
        if (out_free) begin
          if (act_r == ACT_ENQUEUE) begin
            out_data_nxt = '0;
            state_nxt    = S_IDLE;
            out_valid_nxt = 1'b1;
            if (!qok_r || free_head_r == NIL) begin
              out_status_nxt = ST_OVERFLOW;
            end else begin
              out_status_nxt = ST_OK;
              // Untouched slots chain in order; past the fill mark use the link
              if (free_head_r == fill_r) begin
                free_head_nxt = free_head_r + PW'(1);
                fill_nxt      = fill_r + PW'(1);
              end else begin
                free_head_nxt = link_rdata;
              end
              data_we = 1'b1;
              qtab_we = 1'b1;
              qvalid_nxt[q_r] = 1'b1;
              if (cur_head == NIL) begin
                qtab_wdata = {free_head_r, free_head_r};
              end else begin
                qtab_wdata = {cur_head, free_head_r};
                link_we    = 1'b1;
                link_waddr = cur_tail[SW-1:0];
                link_wdata = free_head_r;
              end
            end
          end else if (cur_head == NIL) begin
            out_valid_nxt  = 1'b1;
            out_data_nxt   = '0;
            out_status_nxt = ST_UNDERFLOW;
            state_nxt      = S_IDLE;
          end else begin
            head_nxt   = cur_head;
            tail_nxt   = cur_tail;
            link_re    = 1'b1;
            link_raddr = cur_head[SW-1:0];
            data_re    = 1'b1;
            state_nxt  = S_DEQ;
          end
        end
      end

      // Unlink the head slot, push it on the free list, return its data
      S_DEQ: begin
        if (out_free) begin
          qtab_we        = 1'b1;
          qtab_wdata     = {((head_r == tail_r) ? NIL : link_rdata), tail_r};
          link_we        = 1'b1;
          link_waddr     = head_r[SW-1:0];
          link_wdata     = free_head_r;
          free_head_nxt  = head_r;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = dout_64[DATA_W-1:0];
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, pointers and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      fill_r      <= '0;
      qvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      qvalid_r    <= qvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r        <= act_nxt;
    q_r          <= q_nxt;
    qok_r        <= qok_nxt;
    din_r        <= din_nxt;
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.data_out = out_data_r;
  assign out_ch.status   = out_status_r;

endmodule

`default_nettype wire

/* src/kqsb_checker.sv */
// Port-level checker for k_queues_shared_buffer, attached by bind.
// Depends on kqsb_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module kqsb_checker import kqsb_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [DATA_W-1:0]   out_data,
  input logic [STATUS_W-1:0] out_status
);

  logic       in_xfer, out_xfer;
  logic [1:0] cnt_r, cnt_nxt;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Track requests taken but not yet answered
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_xfer && !out_xfer) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!in_xfer && out_xfer) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  `KQSB_ASSERT_IMPL(a_no_orphan_result, out_valid, cnt_r != 2'd0, "result without a request")
  `KQSB_ASSERT_IMPL(a_ready_bound, in_ready, cnt_r <= 2'd1, "ready with two requests open")
  `KQSB_ASSERT_NEXT(a_min_latency, in_xfer && cnt_r == 2'd0, !out_valid, "result too early")
  `KQSB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_data) && $stable(out_status),
                    "stalled result changed")

endmodule

bind k_queues_shared_buffer kqsb_checker u_kqsb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_data   (out_ch.data_out),
  .out_status (out_ch.status)
);

`default_nettype wire
